// ----- src/ptsb_pkg.sv -----
// Shared types, codes and sizes for the periodic timer slot bank.
`timescale 1ns / 1ps
package ptsb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_TICK    = 3'd3;
  localparam logic [2:0] MODE_SERVICE = 3'd4;

  localparam logic [2:0] KIND_ACK      = 3'd0;
  localparam logic [2:0] KIND_FIRE     = 3'd1;
  localparam logic [2:0] KIND_BADPARAM = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_BADSLOT  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [31:0]        arg;
    logic signed [16:0] repeat_cnt;
    logic [31:0]        remaining;
    logic [31:0]        period;
  } slot_entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] arg;
    logic        last;
  } result_t;

endpackage

// ----- src/periodic_timer_slot_bank_core.sv -----
// Top level of the periodic timer slot bank: slot memory, sequencer and output register.
`timescale 1ns / 1ps
// Init, start and stop: result registered in the cycle after the input beat; one item per
// cycle while the output is not stalled. Tick and service, only while running, walk the slot
// memory one slot per cycle through its single read port, holding on a fire beat while the
// output stalls. Service gives one fire beat per expired slot, then a closing ack with tlast.
// Synchronous reset clears the sequencer, tick counter, run flag and per-slot valid bits;
// slot memory contents need no clearing pass, an invalid slot reads as free.
module periodic_timer_slot_bank_core
  import ptsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // period_ticks[31:0], repeat_count[48:32], user_arg[80:49], slot_select[84:81]
  input  logic [87:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_number[2:0], fired_arg[34:3], tick_value[66:35]
  output logic [71:0] m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  slot_entry_t mem [NUM_SLOTS];
  slot_entry_t rd_data;

  state_t              state, state_next;
  logic                running;
  logic [31:0]         tick_counter;
  logic [NUM_SLOTS-1:0] valid;
  logic [IDX_W-1:0]    idx;
  logic                is_service;

  logic                out_valid;
  result_t             out_res;
  logic [31:0]         out_tick;

  logic [2:0]          in_mode;
  logic [31:0]         in_period;
  logic signed [16:0]  in_repeat;
  logic [31:0]         in_arg;
  logic [3:0]          in_sel;

  logic                acc, can_load, advance, idx_last;
  logic                load;
  result_t             load_res;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  slot_entry_t         mem_wd;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                valid_clr_all, valid_set, valid_clr;
  logic [IDX_W-1:0]    valid_set_idx, valid_clr_idx;
  logic                tick_inc, run_set, walk_start;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic signed [16:0]  rep_new;

  assign in_mode   = s_axis_tuser;
  assign in_period = s_axis_tdata[31:0];
  assign in_repeat = s_axis_tdata[48:32];
  assign in_arg    = s_axis_tdata[80:49];
  assign in_sel    = s_axis_tdata[84:81];

  assign can_load = !out_valid || m_axis_tready;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign idx_last = (idx == IDX_W'(NUM_SLOTS - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (!rd_data.repeat_cnt[16] && (rd_data.repeat_cnt != 17'sd0)) begin
      rep_new = rd_data.repeat_cnt - 17'sd1;
    end else begin
      rep_new = rd_data.repeat_cnt;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (walk_start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (advance && idx_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    load_res      = '0;
    mem_we        = 1'b0;
    mem_wa        = idx;
    mem_wd        = rd_data;
    rd_en         = 1'b0;
    rd_addr       = '0;
    valid_clr_all = 1'b0;
    valid_set     = 1'b0;
    valid_set_idx = free_idx;
    valid_clr     = 1'b0;
    valid_clr_idx = idx;
    tick_inc      = 1'b0;
    run_set       = 1'b0;
    walk_start    = 1'b0;
    advance       = 1'b0;
    load_res.last = 1'b1;
    case (state)
      ST_IDLE: begin
        s_axis_tready = can_load;
        if (acc) begin
          case (in_mode)
            MODE_INIT: begin
              valid_clr_all = 1'b1;
              run_set       = 1'b1;
              load          = 1'b1;
              load_res.kind = KIND_ACK;
            end
            MODE_START: begin
              load = 1'b1;
              if (in_period == 32'd0 || in_repeat == 17'sd0) begin
                load_res.kind = KIND_BADPARAM;
              end else if (!free_found) begin
                load_res.kind = KIND_FULL;
              end else begin
                load_res.kind       = KIND_ACK;
                load_res.slot       = 3'(free_idx);
                mem_we              = 1'b1;
                mem_wa              = free_idx;
                mem_wd.period       = in_period;
                mem_wd.remaining    = in_period;
                mem_wd.repeat_cnt   = in_repeat;
                mem_wd.arg          = in_arg;
                valid_set           = 1'b1;
              end
            end
            MODE_STOP: begin
              load          = 1'b1;
              load_res.slot = in_sel[2:0];
              if (5'(in_sel) >= 5'(NUM_SLOTS)) begin
                load_res.kind = KIND_BADSLOT;
              end else begin
                load_res.kind = KIND_ACK;
                valid_clr     = 1'b1;
                valid_clr_idx = IDX_W'(in_sel);
              end
            end
            MODE_TICK: begin
              if (running) begin
                tick_inc   = 1'b1;
                walk_start = 1'b1;
                rd_en      = 1'b1;
              end
            end
            MODE_SERVICE: begin
              if (running) begin
                walk_start = 1'b1;
                rd_en      = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!is_service) begin
          advance = 1'b1;
          if (valid[idx] && rd_data.remaining != 32'd0) begin
            mem_we           = 1'b1;
            mem_wd.remaining = rd_data.remaining - 32'd1;
          end
        end else if (valid[idx] && rd_data.remaining == 32'd0) begin
          if (can_load) begin
            advance       = 1'b1;
            load          = 1'b1;
            load_res.kind = KIND_FIRE;
            load_res.slot = 3'(idx);
            load_res.arg  = rd_data.arg;
            load_res.last = 1'b0;
            if (rep_new != 17'sd0) begin
              mem_we            = 1'b1;
              mem_wd.remaining  = rd_data.period;
              mem_wd.repeat_cnt = rep_new;
            end else begin
              valid_clr = 1'b1;
            end
          end
        end else begin
          advance = 1'b1;
        end
        if (advance && !idx_last) begin
          rd_en   = 1'b1;
          rd_addr = idx + IDX_W'(1);
        end
      end
      ST_FIN: begin
        if (can_load) begin
          load          = 1'b1;
          load_res.kind = KIND_ACK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running      <= 1'b0;
      tick_counter <= '0;
      valid        <= '0;
      idx          <= '0;
      is_service   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (run_set) begin
        running      <= 1'b1;
        tick_counter <= '0;
      end else if (tick_inc) begin
        tick_counter <= tick_counter + 32'd1;
      end
      if (valid_clr_all) begin
        valid <= '0;
      end else begin
        if (valid_set) valid[valid_set_idx] <= 1'b1;
        if (valid_clr) valid[valid_clr_idx] <= 1'b0;
      end
      if (walk_start) begin
        idx        <= '0;
        is_service <= (in_mode == MODE_SERVICE);
      end else if (advance && !idx_last) begin
        idx <= idx + IDX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tick value follows the counter after the operation; init clears it
  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= load_res;
      out_tick <= run_set ? 32'd0 : tick_counter;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {5'd0, out_tick, out_res.arg, out_res.slot};

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while walking slots");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_FIRE) |-> !m_axis_tlast)
    else $error("fire beat marked last");

  a_walk_closes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && can_load) |=> (m_axis_tvalid && m_axis_tlast &&
                                       m_axis_tuser == KIND_ACK))
    else $error("walk ended without closing ack");

  a_walk_write_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && mem_we) |-> (mem_wa == idx && valid[idx]))
    else $error("slot write outside current valid slot");

endmodule
